// File: design/sha256_pkg.sv
package sha256_pkg;

	localparam int unsigned ROUNDS = 64;
	localparam int unsigned WIN_WORDS = 16;
	localparam int unsigned HASH_WORDS = 8;
	localparam int unsigned OUT_WORDS = 4;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_END = 1'b1;

	localparam logic [7:0] PAD_MARK = 8'h80;

	localparam logic [31:0] ROUND_K [ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] INIT_HASH [HASH_WORDS] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef enum logic [1:0] {
		SRC_INPUT,
		SRC_MARK,
		SRC_ZERO,
		SRC_LENGTH
	} byte_src_t;

	typedef struct packed {
		logic      push;
		byte_src_t src;
		logic      count;
		logic      load;
		logic      round;
		logic [5:0] rnd;
		logic      add;
		logic      init;
		logic [1:0] widx;
	} cmd_t;

	typedef struct packed {
		logic fill_hi;
		logic fill_last;
	} sts_t;

	function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned n);
		return (v >> n) | (v << (32 - n));
	endfunction

	function automatic logic [31:0] big_sigma0(input logic [31:0] v);
		return ror32(v, 2) ^ ror32(v, 13) ^ ror32(v, 22);
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] v);
		return ror32(v, 6) ^ ror32(v, 11) ^ ror32(v, 25);
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] v);
		return ror32(v, 7) ^ ror32(v, 18) ^ (v >> 3);
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] v);
		return ror32(v, 17) ^ ror32(v, 19) ^ (v >> 10);
	endfunction

endpackage

// File: design/sha256_message_hasher.sv
// Channel  Direction  Handshake             Payload
// in       request    in_valid / in_stall   kind, data_byte
// out      result     out_valid / out_stall digest_word, word_index, last_word
//
// A message byte is taken into the block buffer; the byte that completes a 64-byte
// block also starts a compression: a load of the working variables, 64 rounds of the
// single round unit and a fold of the result into the hash.
// An end request pushes the padding one byte a cycle, runs one or two such
// compressions and then offers four digest words, one a cycle when not stalled.
// Requests are stalled while a block is compressed and, after an end request, until the last digest
// word is taken. Reset restores the initial hash values and a zero bit count.
module sha256_message_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] digest_word,
	output logic [1:0]  word_index,
	output logic        last_word
);

	sha256_pkg::cmd_t cmd;
	sha256_pkg::sts_t sts;

	sha256_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.last_word  (last_word),
		.word_index (word_index),
		.sts        (sts),
		.cmd        (cmd)
	);

	sha256_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.data_byte   (data_byte),
		.cmd         (cmd),
		.sts         (sts),
		.digest_word (digest_word)
	);

	a_no_accept_while_output: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("request accepted while digest is offered");

	a_push_not_in_round: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.push && (cmd.round || cmd.load || cmd.add)))
		else $error("byte pushed during compression");

	a_last_word_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last_word) |=> (!out_valid && !in_stall))
		else $error("block not idle after final digest word");

	a_index_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last_word) |=>
		(out_valid && word_index == $past(word_index) + 2'd1))
		else $error("digest word index did not advance");

endmodule

// File: design/sha256_ctrl.sv
module sha256_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                kind,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                last_word,
	output logic [1:0]          word_index,
	input  sha256_pkg::sts_t    sts,
	output sha256_pkg::cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LOAD,
		ST_ROUND,
		ST_ADD,
		ST_OUT
	} state_t;

	state_t     state_q;
	logic [5:0] rnd_q;
	logic [1:0] idx_q;
	logic       first_q;
	logic       extra_q;
	logic       ending_q;

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign word_index = idx_q;
	assign last_word = (idx_q == 2'(sha256_pkg::OUT_WORDS - 1));

	always_comb begin
		cmd = '0;
		cmd.src = sha256_pkg::SRC_INPUT;
		cmd.rnd = rnd_q;
		cmd.widx = idx_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && kind == sha256_pkg::KIND_BYTE) begin
					cmd.push = 1'b1;
					cmd.count = 1'b1;
				end
			end
			ST_PAD: begin
				cmd.push = 1'b1;
				if (first_q) begin
					cmd.src = sha256_pkg::SRC_MARK;
				end else if (sts.fill_hi && !extra_q) begin
					cmd.src = sha256_pkg::SRC_LENGTH;
				end else begin
					cmd.src = sha256_pkg::SRC_ZERO;
				end
			end
			ST_LOAD: cmd.load = 1'b1;
			ST_ROUND: cmd.round = 1'b1;
			ST_ADD: cmd.add = 1'b1;
			ST_OUT: begin
				if (!out_stall && last_word) begin
					cmd.init = 1'b1;
				end
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rnd_q <= '0;
			idx_q <= '0;
			first_q <= 1'b0;
			extra_q <= 1'b0;
			ending_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (kind == sha256_pkg::KIND_BYTE) begin
							if (sts.fill_last) begin
								state_q <= ST_LOAD;
							end
						end else begin
							ending_q <= 1'b1;
							first_q <= 1'b1;
							extra_q <= sts.fill_hi;
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					first_q <= 1'b0;
					if (sts.fill_last) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					rnd_q <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'(sha256_pkg::ROUNDS - 1)) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					if (!ending_q) begin
						state_q <= ST_IDLE;
					end else if (extra_q) begin
						extra_q <= 1'b0;
						state_q <= ST_PAD;
					end else begin
						idx_q <= '0;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_stall) begin
						if (last_word) begin
							ending_q <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + 2'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: design/sha256_dp.sv
module sha256_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       data_byte,
	input  sha256_pkg::cmd_t cmd,
	output sha256_pkg::sts_t sts,
	output logic [63:0]      digest_word
);

	logic [31:0] hash_q [sha256_pkg::HASH_WORDS];
	logic [31:0] var_q [sha256_pkg::HASH_WORDS];
	logic [31:0] win_q [sha256_pkg::WIN_WORDS];
	logic [23:0] acc_q;
	logic [5:0]  fill_q;
	logic [63:0] bitcnt_q;

	logic [7:0]  byte_in;
	logic [31:0] w_next;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] ch;
	logic [31:0] maj;

	assign sts.fill_hi = (fill_q >= 6'd56);
	assign sts.fill_last = (fill_q == 6'd63);

	always_comb begin
		case (cmd.src)
			sha256_pkg::SRC_INPUT: byte_in = data_byte;
			sha256_pkg::SRC_MARK: byte_in = sha256_pkg::PAD_MARK;
			sha256_pkg::SRC_LENGTH: byte_in = bitcnt_q[{~fill_q[2:0], 3'b000} +: 8];
			default: byte_in = 8'h00;
		endcase
	end

	assign w_next = sha256_pkg::small_sigma1(win_q[14]) + win_q[9]
		+ sha256_pkg::small_sigma0(win_q[1]) + win_q[0];
	assign ch = (var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]);
	assign maj = (var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]);
	assign t1 = var_q[7] + sha256_pkg::big_sigma1(var_q[4]) + ch
		+ sha256_pkg::ROUND_K[cmd.rnd] + win_q[0];
	assign t2 = sha256_pkg::big_sigma0(var_q[0]) + maj;

	assign digest_word = {hash_q[{cmd.widx, 1'b0}], hash_q[{cmd.widx, 1'b1}]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			bitcnt_q <= '0;
			for (int i = 0; i < sha256_pkg::HASH_WORDS; i++) begin
				hash_q[i] <= sha256_pkg::INIT_HASH[i];
			end
		end else begin
			if (cmd.push) begin
				fill_q <= fill_q + 6'd1;
			end
			if (cmd.count) begin
				bitcnt_q <= bitcnt_q + 64'd8;
			end else if (cmd.init) begin
				bitcnt_q <= '0;
			end
			if (cmd.add) begin
				for (int i = 0; i < sha256_pkg::HASH_WORDS; i++) begin
					hash_q[i] <= hash_q[i] + var_q[i];
				end
			end else if (cmd.init) begin
				for (int i = 0; i < sha256_pkg::HASH_WORDS; i++) begin
					hash_q[i] <= sha256_pkg::INIT_HASH[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			acc_q <= {acc_q[15:0], byte_in};
		end
		if ((cmd.push && fill_q[1:0] == 2'b11) || cmd.round) begin
			for (int i = 0; i < sha256_pkg::WIN_WORDS - 1; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[sha256_pkg::WIN_WORDS - 1] <= cmd.round ? w_next : {acc_q, byte_in};
		end
		if (cmd.load) begin
			for (int i = 0; i < sha256_pkg::HASH_WORDS; i++) begin
				var_q[i] <= hash_q[i];
			end
		end else if (cmd.round) begin
			var_q[7] <= var_q[6];
			var_q[6] <= var_q[5];
			var_q[5] <= var_q[4];
			var_q[4] <= var_q[3] + t1;
			var_q[3] <= var_q[2];
			var_q[2] <= var_q[1];
			var_q[1] <= var_q[0];
			var_q[0] <= t1 + t2;
		end
	end

endmodule

// File: tb/sha256_message_hasher_checker.sv
module sha256_message_hasher_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        kind,
	input  logic [7:0]  data_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [63:0] digest_word,
	input  logic [1:0]  word_index,
	input  logic        last_word,
	output int          fail_count,
	output int          pending,
	output int          words_checked
);

	typedef struct packed {
		logic [63:0] word;
		logic [1:0]  idx;
		logic        tail;
	} digest_entry_t;

	logic [31:0] chain [sha256_pkg::HASH_WORDS];
	logic [7:0]  block_buf [64];
	logic [63:0] msg_bits;
	digest_entry_t digest_queue [$];

	function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
		logic [63:0] twice;
		twice = {v, v} >> n;
		return twice[31:0];
	endfunction

	function automatic logic [31:0] sum0(input logic [31:0] v);
		return rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
	endfunction

	function automatic logic [31:0] sum1(input logic [31:0] v);
		return rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
	endfunction

	function automatic logic [31:0] mix0(input logic [31:0] v);
		return rotr(v, 7) ^ rotr(v, 18) ^ {3'b000, v[31:3]};
	endfunction

	function automatic logic [31:0] mix1(input logic [31:0] v);
		return rotr(v, 17) ^ rotr(v, 19) ^ {10'b0, v[31:10]};
	endfunction

	function automatic void fold_block();
		logic [31:0] w [16];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
		for (int i = 0; i < 16; i++) begin
			w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
		end
		a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
		e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
		for (int r = 0; r < sha256_pkg::ROUNDS; r++) begin
			if (r >= 16) begin
				w[r % 16] = mix1(w[(r + 14) % 16]) + w[(r + 9) % 16] +
					mix0(w[(r + 1) % 16]) + w[r % 16];
			end
			t1 = h + sum1(e) + ((e & f) ^ (~e & g)) + sha256_pkg::ROUND_K[r] + w[r % 16];
			t2 = sum0(a) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
		chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
	endfunction

	// A byte request fills the block and folds it when full; an end request pads, folds and queues the digest.
	function automatic void absorb_request(input logic k, input logic [7:0] b);
		int pos;
		digest_entry_t entry;
		pos = int'(msg_bits[8:3]);
		if (k == sha256_pkg::KIND_BYTE) begin
			block_buf[pos] = b;
			msg_bits += 64'd8;
			if (pos == 63) fold_block();
		end else begin
			block_buf[pos] = sha256_pkg::PAD_MARK;
			for (int i = pos + 1; i < 64; i++) block_buf[i] = 8'h00;
			if (pos >= 56) begin
				fold_block();
				for (int i = 0; i < 64; i++) block_buf[i] = 8'h00;
			end
			for (int i = 0; i < 8; i++) block_buf[63 - i] = msg_bits[8*i +: 8];
			fold_block();
			for (int i = 0; i < sha256_pkg::OUT_WORDS; i++) begin
				entry.word = {chain[2*i], chain[2*i+1]};
				entry.idx = i[1:0];
				entry.tail = (i == sha256_pkg::OUT_WORDS - 1);
				digest_queue.push_back(entry);
			end
			chain = sha256_pkg::INIT_HASH;
			msg_bits = '0;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		digest_entry_t want;
		int errs;
		if (!arst_n) begin
			chain = sha256_pkg::INIT_HASH;
			msg_bits = '0;
			for (int i = 0; i < 64; i++) block_buf[i] = 8'h00;
			digest_queue.delete();
			fail_count <= 0;
			pending <= 0;
			words_checked <= 0;
		end else begin
			errs = 0;
			if (in_valid && !in_stall) absorb_request(kind, data_byte);
			if (out_valid && !out_stall) begin
				if (digest_queue.size() == 0) begin
					$display("%0t: unexpected digest word %h (index %0d)",
						$time, digest_word, word_index);
					errs++;
				end else begin
					want = digest_queue.pop_front();
					if (digest_word !== want.word) begin
						$display("%0t: digest_word mismatch: expected %h, got %h",
							$time, want.word, digest_word);
						errs++;
					end
					if (word_index !== want.idx) begin
						$display("%0t: word_index mismatch: expected %0d, got %0d",
							$time, want.idx, word_index);
						errs++;
					end
					if (last_word !== want.tail) begin
						$display("%0t: last_word mismatch: expected %0b, got %0b",
							$time, want.tail, last_word);
						errs++;
					end
				end
				words_checked <= words_checked + 1;
			end
			fail_count <= fail_count + errs;
			pending <= digest_queue.size();
		end
	end

endmodule

// File: tb/sha256_message_hasher_tb.sv
module sha256_message_hasher_tb;

	localparam int REQUEST_TARGET = 330;
	localparam int MIN_MESSAGES = 12;
	localparam int IDLE_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 250;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        kind = sha256_pkg::KIND_BYTE;
	logic [7:0]  data_byte = 8'h00;
	logic        out_stall = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic [63:0] digest_word;
	logic [1:0]  word_index;
	logic        last_word;

	int fail_count;
	int pending;
	int words_checked;
	int requests_sent = 0;
	int messages_sent = 0;
	int idle_cycles = 0;
	int out_hold = 0;
	bit eager = 1'b0;

	always #5 clk = ~clk;

	sha256_message_hasher u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.data_byte   (data_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last_word   (last_word)
	);

	sha256_message_hasher_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.kind          (kind),
		.data_byte     (data_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.digest_word   (digest_word),
		.word_index    (word_index),
		.last_word     (last_word),
		.fail_count    (fail_count),
		.pending       (pending),
		.words_checked (words_checked)
	);

	function automatic int draw_wait();
		return eager ? 0 : $urandom_range(0, 16);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			out_hold = 0;
		end else if (out_valid && !out_stall) begin
			out_hold = draw_wait();
			out_stall <= (out_hold != 0);
		end else if (out_hold != 0) begin
			out_hold--;
			out_stall <= (out_hold != 0);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("** sha256_message_hasher: FAILED **");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Valid is only lowered when a gap follows, so back-to-back requests keep it high.
	task automatic push_request(input logic k, input logic [7:0] b);
		int gap;
		gap = draw_wait();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		data_byte <= b;
		do @(posedge clk); while (in_stall);
		requests_sent++;
		if (k == sha256_pkg::KIND_END) begin
			messages_sent++;
			eager = ($urandom_range(0, 3) == 0);
		end
	endtask

	task automatic send_message(input int len);
		for (int i = 0; i < len; i++) begin
			push_request(sha256_pkg::KIND_BYTE, 8'($urandom_range(0, 255)));
		end
		push_request(sha256_pkg::KIND_END, 8'($urandom_range(0, 255)));
	endtask

	initial begin : stimulus
		int len;
		int boundary [4] = '{55, 56, 63, 64};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_request(sha256_pkg::KIND_END, 8'h00);
		push_request(sha256_pkg::KIND_END, 8'hff);
		push_request(sha256_pkg::KIND_BYTE, 8'h61);
		push_request(sha256_pkg::KIND_BYTE, 8'h62);
		push_request(sha256_pkg::KIND_BYTE, 8'h63);
		push_request(sha256_pkg::KIND_END, 8'h00);
		push_request(sha256_pkg::KIND_BYTE, 8'hff);
		push_request(sha256_pkg::KIND_BYTE, 8'h00);
		push_request(sha256_pkg::KIND_END, 8'hff);
		push_request(sha256_pkg::KIND_BYTE, 8'h80);
		push_request(sha256_pkg::KIND_END, 8'h00);

		foreach (boundary[i]) send_message(boundary[i]);
		while (requests_sent < REQUEST_TARGET || messages_sent < MIN_MESSAGES) begin
			case ($urandom_range(0, 3))
				0, 1: begin
					len = $urandom_range(0, 20);
				end
				2: begin
					len = 50 + $urandom_range(0, 20);
				end
				default: begin
					len = $urandom_range(0, 130);
				end
			endcase
			send_message(len);
		end
		in_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Hashed %0d messages from %0d requests, including empty and two-block padding.",
			messages_sent, requests_sent);
		$display("Compared %0d digest words against the predicted digests.", words_checked);
		if (fail_count == 0) begin
			$display("** sha256_message_hasher: PASSED **");
		end else begin
			$display("** sha256_message_hasher: FAILED **");
		end
		$finish;
	end

endmodule
